[rtl/avcc_to_annexb_converter_defines.svh]
// assertion macros shared by the converter rtl
// no dependencies; taken in by files that carry concurrent assertions
`ifndef AVCC_TO_ANNEXB_CONVERTER_DEFINES_SVH
`define AVCC_TO_ANNEXB_CONVERTER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define A2AB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("a2ab check failed");

// next-cycle implication checked outside reset
`define A2AB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("a2ab check failed");

`endif

[rtl/a2ab_pkg.sv]
// shared types and constants for the avcc to annex b converter
// no dependencies
package a2ab_pkg;

    localparam int MAX_SAMPLE_BYTES_DEF = 4194304;

    localparam int NAL_TYPE_W = 5;
    localparam logic [NAL_TYPE_W-1:0] TYPE_SPS   = 5'h07;
    localparam logic [NAL_TYPE_W-1:0] TYPE_IDR   = 5'h05;
    localparam logic [NAL_TYPE_W-1:0] TYPE_SLICE = 5'h01;

    localparam logic [7:0] START_CODE_ZERO = 8'h00;
    localparam logic [7:0] START_CODE_ONE  = 8'h01;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       sample_end;
    } t_in_item;

    // input register contents handed to the core
    typedef struct packed {
        logic     vld;
        t_in_item item;
    } t_in_stage;

endpackage

[rtl/a2ab_if.sv]
// valid/ready channel interfaces for the converter input and output
// no dependencies
interface a2ab_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       sample_end;

    modport source (output valid, output in_byte, output sample_end, input ready);
    modport sink (input valid, input in_byte, input sample_end, output ready);
endinterface

interface a2ab_out_if #(
    parameter int POS_W = 22
);
    logic             valid;
    logic             ready;
    logic [7:0]       out_byte;
    logic             out_last;
    logic             key_frame;
    logic [POS_W-1:0] frame_start;
    logic [POS_W:0]   frame_length;

    modport source (
        output valid, output out_byte, output out_last, output key_frame,
        output frame_start, output frame_length, input ready
    );
    modport sink (
        input valid, input out_byte, input out_last, input key_frame,
        input frame_start, input frame_length, output ready
    );
endinterface

[rtl/a2ab_in_reg.sv]
// input register stage of the converter
// depends on a2ab_pkg and a2ab_in_if
module a2ab_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    a2ab_in_if.sink             i_in,
    input  logic                i_adv,
    output a2ab_pkg::t_in_stage o_stage
);

    logic               r_vld;
    a2ab_pkg::t_in_item r_item;
    logic               w_take;

    // free slot, or the held byte leaves this cycle
    assign i_in.ready = !r_vld || i_adv;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (i_adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.in_byte    <= i_in.in_byte;
            r_item.sample_end <= i_in.sample_end;
        end
    end

    assign o_stage.vld  = r_vld;
    assign o_stage.item = r_item;

endmodule

[rtl/a2ab_core.sv]
// header parser, frame bookkeeping and result register
// depends on a2ab_pkg, a2ab_out_if and the assertion macro header
`include "avcc_to_annexb_converter_defines.svh"

module a2ab_core #(
    parameter int MAX_SAMPLE_BYTES = a2ab_pkg::MAX_SAMPLE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  a2ab_pkg::t_in_stage i_stage,
    output logic                o_adv,
    a2ab_out_if.source          o_out
);

    localparam int POS_W = $clog2(MAX_SAMPLE_BYTES);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SAMPLE_BYTES - 1);
    localparam logic [POS_W-1:0] LEN_FIELD = POS_W'(4);

    typedef enum logic [2:0] {
        PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3, PH_HEADER, PH_PAYLOAD
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [23:0]      r_gather, n_gather;
    logic [31:0]      r_left, n_left;
    logic             r_key, n_key;
    logic             r_slice, n_slice;
    logic [POS_W-1:0] r_chosen, n_chosen;

    logic             r_out_vld;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last;
    logic             r_out_key, n_out_key;
    logic [POS_W-1:0] r_out_start, n_out_start;
    logic [POS_W:0]   r_out_len, n_out_len;

    logic [7:0]                      w_b;
    logic [a2ab_pkg::NAL_TYPE_W-1:0] w_type;
    logic [POS_W-1:0]                w_start;
    logic [31:0]                     w_full_len;
    logic [POS_W:0]                  w_end;

    assign o_adv      = i_stage.vld && (!r_out_vld || o_out.ready);
    assign w_b        = i_stage.item.in_byte;
    assign w_type     = w_b[a2ab_pkg::NAL_TYPE_W-1:0];
    assign w_start    = (r_pos >= LEN_FIELD) ? (r_pos - LEN_FIELD) : '0;
    assign w_full_len = {r_gather, w_b};
    assign w_end      = {1'b0, r_pos} + (POS_W+1)'(1);

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_gather    = r_gather;
        n_left      = r_left;
        n_key       = r_key;
        n_slice     = r_slice;
        n_chosen    = r_chosen;
        n_out_byte  = a2ab_pkg::START_CODE_ZERO;
        n_out_key   = 1'b0;
        n_out_start = '0;
        n_out_len   = '0;

        case (r_phase)
            PH_HEADER: begin
                n_out_byte = w_b;
                if ((w_type == a2ab_pkg::TYPE_SPS || w_type == a2ab_pkg::TYPE_IDR) && !r_key) begin
                    n_key    = 1'b1;
                    n_chosen = w_start;
                end
                if (w_type == a2ab_pkg::TYPE_SLICE && !r_slice) begin
                    n_slice  = 1'b1;
                    n_chosen = w_start;
                end
                n_left  = r_left - 32'd1;
                n_phase = (r_left == 32'd1) ? PH_LEN0 : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_out_byte = w_b;
                n_left     = r_left - 32'd1;
                if (r_left == 32'd1) begin
                    n_phase = PH_LEN0;
                end
            end
            PH_LEN1: begin
                n_gather = {r_gather[15:0], w_b};
                n_phase  = PH_LEN2;
            end
            PH_LEN2: begin
                n_gather = {r_gather[15:0], w_b};
                n_phase  = PH_LEN3;
            end
            PH_LEN3: begin
                n_gather   = {r_gather[15:0], w_b};
                n_out_byte = a2ab_pkg::START_CODE_ONE;
                // zero-length nal carries no header byte
                if (w_full_len == 32'd0) begin
                    n_phase = PH_LEN0;
                end else begin
                    n_left  = w_full_len;
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                n_gather = {16'd0, w_b};
                n_phase  = PH_LEN1;
            end
        endcase

        if (i_stage.item.sample_end) begin
            n_out_key   = n_key;
            n_out_start = n_chosen;
            n_out_len   = (w_end >= {1'b0, n_chosen}) ? (w_end - {1'b0, n_chosen}) : '0;
            // back to a clean start for the next sample
            n_phase  = PH_LEN0;
            n_pos    = '0;
            n_gather = '0;
            n_left   = '0;
            n_key    = 1'b0;
            n_slice  = 1'b0;
            n_chosen = '0;
        end else if (r_pos < POS_MAX) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN0;
            r_pos     <= '0;
            r_gather  <= '0;
            r_left    <= '0;
            r_key     <= 1'b0;
            r_slice   <= 1'b0;
            r_chosen  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_adv) begin
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_gather <= n_gather;
                r_left   <= n_left;
                r_key    <= n_key;
                r_slice  <= n_slice;
                r_chosen <= n_chosen;
            end
            if (o_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_out_byte  <= n_out_byte;
            r_out_last  <= i_stage.item.sample_end;
            r_out_key   <= n_out_key;
            r_out_start <= n_out_start;
            r_out_len   <= n_out_len;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.out_last     = r_out_last;
    assign o_out.key_frame    = r_out_key;
    assign o_out.frame_start  = r_out_start;
    assign o_out.frame_length = r_out_len;

    `A2AB_ASSERT_IMPLY(a_frame_zero_mid, i_clk, i_rst_n, r_out_vld && !r_out_last, !r_out_key && r_out_start == '0 && r_out_len == '0)
    `A2AB_ASSERT_IMPLY(a_frame_len_nz, i_clk, i_rst_n, r_out_vld && r_out_last, r_out_len != '0)
    `A2AB_ASSERT_IMPLY(a_left_nz, i_clk, i_rst_n, r_phase == PH_HEADER || r_phase == PH_PAYLOAD, r_left != 32'd0)
    `A2AB_ASSERT_NEXT(a_clear_end, i_clk, i_rst_n, o_adv && i_stage.item.sample_end, r_pos == '0 && r_phase == PH_LEN0 && !r_key && !r_slice)

endmodule

[rtl/avcc_to_annexb_converter.sv]
// top level of the avcc to annex b converter
// depends on a2ab_pkg, a2ab_if, a2ab_in_reg and a2ab_core
//
//  channel  | dir | transfer contents
//  ---------+-----+---------------------------------------------------------
//  i_in     | in  | in_byte, sample_end
//  o_out    | out | out_byte, out_last, key_frame, frame_start, frame_length
//
// bytes pass the input register, then the result register; one byte per cycle while
// o_out is ready; the parse state is updated as a byte leaves the input register
// synchronous active-low reset clears both valid flags and all parse state
// o_out stalls hold the result register; the input register still takes a byte
// until it too is full, so i_in.ready follows o_out.ready only when both are full
module avcc_to_annexb_converter #(
    parameter int MAX_SAMPLE_BYTES = a2ab_pkg::MAX_SAMPLE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    a2ab_in_if.sink    i_in,
    a2ab_out_if.source o_out
);

    // input register contents and the advance strobe between the stages
    a2ab_pkg::t_in_stage w_stage;
    logic                w_adv;

    // input register: byte and end flag wait here for the parser
    a2ab_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (w_adv),
        .o_stage (w_stage)
    );

    // parser: length to start code rewrite, key and offset tracking, result register
    a2ab_core #(
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );

endmodule

[tb/avcc_to_annexb_converter_tb.sv]
// self-checking testbench for the avcc to annex b converter
// depends on a2ab_pkg, a2ab_if and the converter rtl; a directed table is run,
// then random length-prefixed samples, each result checked against a predictor
module avcc_to_annexb_converter_tb;

    localparam int          RANDOM_ITEMS = 700;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [21:0] POS_CEIL     = 22'(a2ab_pkg::MAX_SAMPLE_BYTES_DEF - 1);

    // parse phases of the converter: four length bytes, nal header, nal body
    localparam logic [2:0] PH_LEN0 = 3'd0;
    localparam logic [2:0] PH_LEN3 = 3'd3;
    localparam logic [2:0] PH_HDR  = 3'd4;
    localparam logic [2:0] PH_BODY = 3'd5;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic        key_frame;
        logic [21:0] frame_start;
        logic [22:0] frame_length;
    } t_annexb_res;

    // one input byte; fixed marks a row whose result is written out by hand
    typedef struct packed {
        logic [7:0]  b;
        logic        last;
        logic        fixed;
        t_annexb_res res;
    } t_avcc_item;

    localparam t_annexb_res NO_RES = '0;

    // directed samples, in order:
    //   single byte sample straight after reset
    //   all-ones length with an idr header, sample cut inside the nal
    //   sample that ends inside a length field
    //   zero-length nal, then sps, then a slice whose offset wins
    localparam t_avcc_item DIR_TBL [24] = '{
        '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 22'd0, 23'd1}},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hE5, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 22'd0, 23'd7}},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h12, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 22'd0, 23'd2}},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h67, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h41, 1'b1, 1'b0, NO_RES}
    };

    logic i_clk;
    logic i_rst_n;

    a2ab_in_if  in_ch ();
    a2ab_out_if out_ch ();

    avcc_to_annexb_converter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // byte source and converted bytes still owed by the block
    t_avcc_item  avcc_src_q [$];
    t_annexb_res annexb_due_q [$];

    // predictor state, mirrors the parser of the block
    logic [21:0] conv_pos;
    logic [2:0]  conv_phase;
    logic [31:0] conv_len;
    logic [31:0] conv_left;
    logic        conv_key;
    logic        conv_slice;
    logic [21:0] conv_chosen;

    int n_total;
    int n_taken;
    int n_results;
    int n_samples;
    int n_keys;
    int n_errors;
    int n_cycles;
    int burst_left;
    int gap_left;
    int rx_mode;
    int rx_mode_left;
    int rx_tick;
    logic cur_fixed;
    t_annexb_res cur_res;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic annexb_clear();
        conv_pos    = '0;
        conv_phase  = PH_LEN0;
        conv_len    = '0;
        conv_left   = '0;
        conv_key    = 1'b0;
        conv_slice  = 1'b0;
        conv_chosen = '0;
    endtask

    // converts one avcc byte and advances the parse state
    task automatic annexb_convert(input logic [7:0] b, input logic last,
                                  output t_annexb_res r);
        logic [4:0]  nal_type;
        logic [21:0] nal_off;
        logic [2:0]  len_ph;
        logic [22:0] end_pos;
        r = '0;
        if (conv_phase == PH_HDR) begin
            nal_type = b[4:0];
            // offset of the nal's length field
            nal_off = (conv_pos >= 22'd4) ? conv_pos - 22'd4 : '0;
            r.out_byte = b;
            if ((nal_type == a2ab_pkg::TYPE_SPS || nal_type == a2ab_pkg::TYPE_IDR)
                    && !conv_key) begin
                conv_key    = 1'b1;
                conv_chosen = nal_off;
            end
            if (nal_type == a2ab_pkg::TYPE_SLICE && !conv_slice) begin
                conv_slice  = 1'b1;
                conv_chosen = nal_off;
            end
            conv_left  = conv_left - 32'd1;
            conv_phase = (conv_left == '0) ? PH_LEN0 : PH_BODY;
        end else if (conv_phase == PH_BODY) begin
            r.out_byte = b;
            conv_left  = conv_left - 32'd1;
            if (conv_left == '0)
                conv_phase = PH_LEN0;
        end else begin
            // unused phase codes behave as the first length byte
            len_ph   = (conv_phase <= PH_LEN3) ? conv_phase : PH_LEN0;
            conv_len = (len_ph == PH_LEN0) ? {24'd0, b} : {conv_len[23:0], b};
            r.out_byte = (len_ph == PH_LEN3) ? a2ab_pkg::START_CODE_ONE
                                             : a2ab_pkg::START_CODE_ZERO;
            if (len_ph == PH_LEN3) begin
                if (conv_len == '0) begin
                    // zero-length nal: straight on to the next length
                    conv_phase = PH_LEN0;
                end else begin
                    conv_left  = conv_len;
                    conv_phase = PH_HDR;
                end
            end else begin
                conv_phase = len_ph + 3'd1;
            end
        end
        r.out_last = last;
        if (last) begin
            end_pos = {1'b0, conv_pos} + 23'd1;
            r.key_frame    = conv_key;
            r.frame_start  = conv_chosen;
            r.frame_length = (end_pos >= {1'b0, conv_chosen}) ?
                             end_pos - {1'b0, conv_chosen} : '0;
            annexb_clear();
        end else if (conv_pos < POS_CEIL) begin
            conv_pos = conv_pos + 22'd1;
        end
    endtask

    // one random sample: mostly well-formed nals with random content,
    // some cut short, some pure noise, some with a length past the end
    task automatic avcc_add_sample(inout int n_random);
        logic [7:0]  buf_q [$];
        logic [31:0] nal_len;
        logic [7:0]  rb;
        logic [4:0]  nal_type;
        t_avcc_item  it;
        int kind;
        int n_nal;
        int cut;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n_nal = $urandom_range(1, 12);
            repeat (n_nal) begin
                rb = 8'($urandom_range(0, 255));
                buf_q.push_back(rb);
            end
        end else begin
            n_nal = $urandom_range(1, 4);
            for (int k = 0; k < n_nal; k++) begin
                if ($urandom_range(0, 15) == 0)
                    nal_len = $urandom;
                else if ($urandom_range(0, 9) == 0)
                    nal_len = '0;
                else
                    nal_len = 32'($urandom_range(1, 10));
                buf_q.push_back(nal_len[31:24]);
                buf_q.push_back(nal_len[23:16]);
                buf_q.push_back(nal_len[15:8]);
                buf_q.push_back(nal_len[7:0]);
                if (nal_len != '0) begin
                    case ($urandom_range(0, 4))
                        0:       nal_type = a2ab_pkg::TYPE_SPS;
                        1:       nal_type = a2ab_pkg::TYPE_IDR;
                        2, 3:    nal_type = a2ab_pkg::TYPE_SLICE;
                        default: nal_type = 5'($urandom_range(0, 31));
                    endcase
                    rb = {3'($urandom_range(0, 7)), nal_type};
                    buf_q.push_back(rb);
                    // huge lengths get a short body, so the sample ends mid nal
                    for (int j = 1; j < nal_len && j < 24; j++) begin
                        rb = 8'($urandom_range(0, 255));
                        buf_q.push_back(rb);
                    end
                end
            end
            if (kind == 1) begin
                cut = $urandom_range(1, buf_q.size());
                while (buf_q.size() > cut)
                    void'(buf_q.pop_back());
            end
        end
        foreach (buf_q[i]) begin
            it       = '0;
            it.b     = buf_q[i];
            it.last  = (i == buf_q.size() - 1);
            avcc_src_q.push_back(it);
        end
        n_random += buf_q.size();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_errors < 20)
            $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
                     what, n_results, got, want);
        n_errors++;
    endtask

    // sender: bursts of random length with random gaps, prediction at transfer
    always @(posedge i_clk) begin
        t_annexb_res pred;
        t_avcc_item  it;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                annexb_convert(in_ch.in_byte, in_ch.sample_end, pred);
                annexb_due_q.push_back(cur_fixed ? cur_res : pred);
                n_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (avcc_src_q.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else begin
                    it = avcc_src_q.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.in_byte    <= it.b;
                    in_ch.sample_end <= it.last;
                    cur_fixed        <= it.fixed;
                    cur_res          <= it.res;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // now and then a long stretch without gaps
                        burst_left = ($urandom_range(0, 7) == 0) ?
                                     $urandom_range(100, 250) : $urandom_range(1, 40);
                        gap_left   = $urandom_range(0, 7);
                    end
                end
            end
        end
    end

    // receiver: stall pattern switches between steady, random, periodic, heavy
    always @(posedge i_clk) begin
        logic rdy;
        rx_tick++;
        case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = (rx_tick % 5) != 0;
            default: rdy = ($urandom_range(0, 3) == 0);
        endcase
        if (rx_mode_left > 0) begin
            rx_mode_left--;
        end else begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
        end
        out_ch.ready <= i_rst_n ? rdy : 1'b0;
    end

    // result checker, field by field against the oldest due byte
    always @(posedge i_clk) begin
        t_annexb_res got;
        t_annexb_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.out_byte     = out_ch.out_byte;
            got.out_last     = out_ch.out_last;
            got.key_frame    = out_ch.key_frame;
            got.frame_start  = out_ch.frame_start;
            got.frame_length = out_ch.frame_length;
            if (annexb_due_q.size() == 0) begin
                report_mismatch("unexpected transfer", 32'(got.out_byte), '0);
            end else begin
                want = annexb_due_q.pop_front();
                if (got.out_byte !== want.out_byte)
                    report_mismatch("out_byte", 32'(got.out_byte),
                                    32'(want.out_byte));
                if (got.out_last !== want.out_last)
                    report_mismatch("out_last", 32'(got.out_last),
                                    32'(want.out_last));
                if (got.key_frame !== want.key_frame)
                    report_mismatch("key_frame", 32'(got.key_frame),
                                    32'(want.key_frame));
                if (got.frame_start !== want.frame_start)
                    report_mismatch("frame_start", 32'(got.frame_start),
                                    32'(want.frame_start));
                if (got.frame_length !== want.frame_length)
                    report_mismatch("frame_length", 32'(got.frame_length),
                                    32'(want.frame_length));
            end
            n_results++;
            if (got.out_last === 1'b1) begin
                n_samples++;
                if (got.key_frame === 1'b1)
                    n_keys++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d bytes taken, %0d results due",
                     n_cycles, n_taken, n_total, annexb_due_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int n_random;
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = '0;
        in_ch.sample_end = 1'b0;
        out_ch.ready     = 1'b0;
        i_rst_n          = 1'b0;
        cur_fixed        = 1'b0;
        cur_res          = '0;
        n_taken          = 0;
        n_results        = 0;
        n_samples        = 0;
        n_keys           = 0;
        n_errors         = 0;
        n_cycles         = 0;
        burst_left       = 1;
        gap_left         = 0;
        rx_mode          = 0;
        rx_mode_left     = 0;
        rx_tick          = 0;
        n_random         = 0;
        annexb_clear();

        foreach (DIR_TBL[i])
            avcc_src_q.push_back(DIR_TBL[i]);
        while (n_random < RANDOM_ITEMS)
            avcc_add_sample(n_random);
        n_total = avcc_src_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_total)
            @(posedge i_clk);
        while (annexb_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d bytes across %0d samples, %0d reported as key frames",
                 n_results, n_samples, n_keys);
        $display("%0d mismatches", n_errors);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
